// File: rtl/okes_pkg.sv
`timescale 1ns / 1ps

package okes_pkg;

    // Fixed-point format of positions, velocities, accelerations and time.
    localparam int FRAC_BITS = 16;

    localparam int DATA_W = 32;
    localparam int TIME_W = 31;
    // Dividend of the acceleration: magnitude shifted up by three fraction widths.
    localparam int NUM_W  = DATA_W + 3 * FRAC_BITS;
    // r^3 with r below 2^32.
    localparam int DEN_W  = 3 * DATA_W;
    // Divisor aligned to the top quotient bit.
    localparam int DSH_W  = DEN_W + DATA_W - 1;
    localparam int SQ_W   = 2 * DATA_W;
    localparam int SUM_W  = 2 * DATA_W - FRAC_BITS + 1;

    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [TIME_W-1:0]        TIME_MAX = {TIME_W{1'b1}};

    localparam logic [TIME_W-1:0] STEP_SIZE_RST = TIME_W'(655);
    localparam logic [TIME_W-1:0] END_TIME_RST  = TIME_W'(65536);

    // Command codes.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes.
    localparam logic REG_STEP_SIZE = 1'b0;
    localparam logic REG_END_TIME  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] step_size;
        logic [TIME_W-1:0] end_time;
    } cfg_t;

    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] load_x;
        logic signed [DATA_W-1:0] load_vx;
        logic signed [DATA_W-1:0] load_y;
        logic signed [DATA_W-1:0] load_vy;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] new_x;
        logic signed [DATA_W-1:0] new_vx;
        logic signed [DATA_W-1:0] new_y;
        logic signed [DATA_W-1:0] new_vy;
        logic [TIME_W-1:0]        step_time;
        logic                     zero_radius;
    } out_item_t;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SQX    = 11'b00000000010,
        S_SQY    = 11'b00000000100,
        S_SQSUM  = 11'b00000001000,
        S_SQRT   = 11'b00000010000,
        S_CUBE_A = 11'b00000100000,
        S_CUBE_B = 11'b00001000000,
        S_CUBE_C = 11'b00010000000,
        S_CUBE_D = 11'b00100000000,
        S_DIV    = 11'b01000000000,
        S_EMUL   = 11'b10000000000
    } state_t;

    // Magnitude of a signed word as an unsigned word (the most negative value maps to 2^31).
    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        mag32 = v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
    endfunction

endpackage

// File: rtl/okes_if.sv
`timescale 1ns / 1ps

// Request channel carrying load and step commands.
interface okes_in_if;
    logic                               valid;
    logic                               ready;
    logic                               command;
    logic signed [okes_pkg::DATA_W-1:0] load_x;
    logic signed [okes_pkg::DATA_W-1:0] load_vx;
    logic signed [okes_pkg::DATA_W-1:0] load_y;
    logic signed [okes_pkg::DATA_W-1:0] load_vy;

    modport source (output valid, command, load_x, load_vx, load_y, load_vy, input ready);
    modport sink (input valid, command, load_x, load_vx, load_y, load_vy, output ready);
endinterface

// Result channel carrying the state after each step.
interface okes_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [okes_pkg::DATA_W-1:0] new_x;
    logic signed [okes_pkg::DATA_W-1:0] new_vx;
    logic signed [okes_pkg::DATA_W-1:0] new_y;
    logic signed [okes_pkg::DATA_W-1:0] new_vy;
    logic [okes_pkg::TIME_W-1:0]        step_time;
    logic                               zero_radius;

    modport source (output valid, new_x, new_vx, new_y, new_vy, step_time, zero_radius,
                    input ready);
    modport sink (input valid, new_x, new_vx, new_y, new_vy, step_time, zero_radius,
                  output ready);
endinterface

// File: rtl/okes_mul.sv
`timescale 1ns / 1ps

// Shared 32 x 32 unsigned multiplier with a registered product.
module okes_mul (
    input  logic                            clk,
    input  logic [okes_pkg::DATA_W-1:0]     a,
    input  logic [okes_pkg::DATA_W-1:0]     b,
    output logic [2*okes_pkg::DATA_W-1:0]   p
);

    logic [2*okes_pkg::DATA_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: rtl/okes_core.sv
`timescale 1ns / 1ps

// Sequencer and datapath: squares, bit-serial square root, cube, two
// restoring divisions and four Euler updates; all products share one
// multiplier and the two divisions share one shift-subtract stage.
module okes_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  okes_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  okes_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output okes_pkg::out_item_t  out_item
);

    localparam int DW = okes_pkg::DATA_W;
    localparam int FB = okes_pkg::FRAC_BITS;

    okes_pkg::state_t state_reg, state_next;

    logic signed [DW-1:0] x_reg, vx_reg, y_reg, vy_reg;
    logic [okes_pkg::TIME_W-1:0] elapsed_reg;

    logic [okes_pkg::SQ_W-1:0]  sq_rem_reg, sq_res_reg, sq_bit_reg;
    logic [4:0]                 sq_cnt_reg;
    logic [okes_pkg::DEN_W-1:0] den_reg;
    logic [DW-1:0]              rr_hi_reg;
    logic [okes_pkg::NUM_W-1:0] dv_rem_reg;
    logic [okes_pkg::DSH_W-1:0] dv_dsh_reg;
    logic [4:0]                 dv_cnt_reg;
    logic [DW-1:0]              dv_q_reg;
    logic                       axis_reg;
    logic signed [DW-1:0]       ax_reg, ay_reg;
    logic                       zr_reg;
    logic [1:0]                 eidx_reg;
    logic                       ephase_reg;

    logic                       out_valid_reg;
    okes_pkg::out_item_t        out_item_reg;

    logic [DW-1:0]   mul_a, mul_b;
    logic [2*DW-1:0] mul_p;

    logic in_fire, out_fire, step_late, publish;

    okes_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign in_ready  = (state_reg == okes_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign step_late = (elapsed_reg >= cfg.end_time);
    assign publish   = (state_reg == okes_pkg::S_EMUL) && ephase_reg && eidx_reg == 2'd3
                       && (!out_valid_reg || out_ready);

    // Euler operand selection: base value and rate for each of the four updates.
    logic signed [DW-1:0] e_base, e_rate;

    always_comb
    begin
        case (eidx_reg)
            2'd0:    begin e_base = x_reg;  e_rate = vx_reg; end
            2'd1:    begin e_base = vx_reg; e_rate = ax_reg; end
            2'd2:    begin e_base = y_reg;  e_rate = vy_reg; end
            default: begin e_base = vy_reg; e_rate = ay_reg; end
        endcase
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            okes_pkg::S_SQX:
            begin
                mul_a = okes_pkg::mag32(x_reg);
                mul_b = okes_pkg::mag32(x_reg);
            end
            okes_pkg::S_SQY:
            begin
                mul_a = okes_pkg::mag32(y_reg);
                mul_b = okes_pkg::mag32(y_reg);
            end
            okes_pkg::S_CUBE_A:
            begin
                mul_a = sq_res_reg[DW-1:0];
                mul_b = sq_res_reg[DW-1:0];
            end
            okes_pkg::S_CUBE_B:
            begin
                mul_a = mul_p[DW-1:0];
                mul_b = sq_res_reg[DW-1:0];
            end
            okes_pkg::S_CUBE_C:
            begin
                mul_a = rr_hi_reg;
                mul_b = sq_res_reg[DW-1:0];
            end
            okes_pkg::S_EMUL:
            begin
                mul_a = DW'(cfg.step_size);
                mul_b = okes_pkg::mag32(e_rate);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Square root iteration.
    logic [okes_pkg::SQ_W-1:0] sq_trial, sq_rem_new, sq_res_new;

    always_comb
    begin
        sq_trial = sq_res_reg + sq_bit_reg;
        if (sq_rem_reg >= sq_trial)
        begin
            sq_rem_new = sq_rem_reg - sq_trial;
            sq_res_new = (sq_res_reg >> 1) + sq_bit_reg;
        end
        else
        begin
            sq_rem_new = sq_rem_reg;
            sq_res_new = sq_res_reg >> 1;
        end
    end

    // Division iteration and acceleration value.
    logic                       dv_ge, dv_done;
    logic [okes_pkg::NUM_W-1:0] dv_rem_new;
    logic [DW-1:0]              dv_q_new;
    logic signed [DW-1:0]       dv_c, acc_val;

    always_comb
    begin
        dv_ge      = (okes_pkg::DSH_W'(dv_rem_reg) >= dv_dsh_reg);
        dv_rem_new = dv_rem_reg;
        dv_q_new   = dv_q_reg;
        dv_done    = (dv_cnt_reg == 5'd0);
        if (dv_cnt_reg == 5'd31 && dv_ge)
        begin
            // Quotient does not fit: clamp to 2^31.
            dv_q_new = {1'b1, {(DW-1){1'b0}}};
            dv_done  = 1'b1;
        end
        else if (dv_ge)
        begin
            dv_rem_new           = dv_rem_reg - dv_dsh_reg[okes_pkg::NUM_W-1:0];
            dv_q_new[dv_cnt_reg] = 1'b1;
        end
        dv_c = axis_reg ? y_reg : x_reg;
        if (dv_c > 0)
        begin
            acc_val = -$signed(dv_q_new);
        end
        else if (dv_q_new[DW-1])
        begin
            acc_val = okes_pkg::S32_MAX;
        end
        else
        begin
            acc_val = $signed(dv_q_new);
        end
    end

    // Euler update: floor(dt * rate / 2^FRAC_BITS) added to the base, saturated.
    logic [2*DW-1:0]                 e_sp;
    logic signed [okes_pkg::SUM_W-1:0] e_sum;
    logic signed [DW-1:0]            e_val;

    always_comb
    begin
        e_sp  = e_rate[DW-1] ? (~mul_p + (2*DW)'(1)) : mul_p;
        e_sum = okes_pkg::SUM_W'(e_base)
              + okes_pkg::SUM_W'($signed(e_sp[2*DW-1:FB]));
        if (e_sum > okes_pkg::SUM_W'(okes_pkg::S32_MAX))
        begin
            e_val = okes_pkg::S32_MAX;
        end
        else if (e_sum < okes_pkg::SUM_W'(okes_pkg::S32_MIN))
        begin
            e_val = okes_pkg::S32_MIN;
        end
        else
        begin
            e_val = e_sum[DW-1:0];
        end
    end

    // Saturating time advance.
    logic [okes_pkg::TIME_W:0]   t_sum;
    logic [okes_pkg::TIME_W-1:0] t_next;

    assign t_sum  = {1'b0, elapsed_reg} + {1'b0, cfg.step_size};
    assign t_next = t_sum[okes_pkg::TIME_W] ? okes_pkg::TIME_MAX
                                            : t_sum[okes_pkg::TIME_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            okes_pkg::S_IDLE:
            begin
                if (in_fire && in_item.command == okes_pkg::CMD_STEP && !step_late)
                begin
                    state_next = okes_pkg::S_SQX;
                end
            end
            okes_pkg::S_SQX:    state_next = okes_pkg::S_SQY;
            okes_pkg::S_SQY:    state_next = okes_pkg::S_SQSUM;
            okes_pkg::S_SQSUM:  state_next = okes_pkg::S_SQRT;
            okes_pkg::S_SQRT:
            begin
                if (sq_cnt_reg == 5'd31)
                begin
                    state_next = (sq_res_new == '0) ? okes_pkg::S_EMUL
                                                    : okes_pkg::S_CUBE_A;
                end
            end
            okes_pkg::S_CUBE_A: state_next = okes_pkg::S_CUBE_B;
            okes_pkg::S_CUBE_B: state_next = okes_pkg::S_CUBE_C;
            okes_pkg::S_CUBE_C: state_next = okes_pkg::S_CUBE_D;
            okes_pkg::S_CUBE_D: state_next = okes_pkg::S_DIV;
            okes_pkg::S_DIV:
            begin
                if (dv_done && axis_reg)
                begin
                    state_next = okes_pkg::S_EMUL;
                end
            end
            okes_pkg::S_EMUL:
            begin
                if (ephase_reg && eidx_reg == 2'd3 && (!out_valid_reg || out_ready))
                begin
                    state_next = okes_pkg::S_IDLE;
                end
            end
            default:            state_next = okes_pkg::S_IDLE;
        endcase
    end

    // Result valid flag: set when a step result is published, cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= okes_pkg::S_IDLE;
            x_reg         <= '0;
            vx_reg        <= '0;
            y_reg         <= '0;
            vy_reg        <= '0;
            elapsed_reg   <= '0;
            eidx_reg      <= '0;
            ephase_reg    <= 1'b0;
            axis_reg      <= 1'b0;
            zr_reg        <= 1'b0;
            ax_reg        <= '0;
            ay_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;

            unique case (state_reg)
                okes_pkg::S_IDLE:
                begin
                    if (in_fire && in_item.command == okes_pkg::CMD_LOAD)
                    begin
                        x_reg       <= in_item.load_x;
                        vx_reg      <= in_item.load_vx;
                        y_reg       <= in_item.load_y;
                        vy_reg      <= in_item.load_vy;
                        elapsed_reg <= '0;
                    end
                    eidx_reg   <= '0;
                    ephase_reg <= 1'b0;
                    axis_reg   <= 1'b0;
                end
                okes_pkg::S_SQRT:
                begin
                    if (sq_cnt_reg == 5'd31 && sq_res_new == '0)
                    begin
                        zr_reg <= 1'b1;
                        ax_reg <= okes_pkg::S32_MIN;
                        ay_reg <= okes_pkg::S32_MIN;
                    end
                    else
                    begin
                        zr_reg <= 1'b0;
                    end
                end
                okes_pkg::S_DIV:
                begin
                    if (dv_done)
                    begin
                        axis_reg <= 1'b1;
                        if (axis_reg)
                        begin
                            ay_reg <= acc_val;
                        end
                        else
                        begin
                            ax_reg <= acc_val;
                        end
                    end
                end
                okes_pkg::S_EMUL:
                begin
                    // Phase 0 issues the product; phase 1 folds it into the state.
                    if (!ephase_reg)
                    begin
                        ephase_reg <= 1'b1;
                    end
                    else if (eidx_reg != 2'd3)
                    begin
                        ephase_reg <= 1'b0;
                        eidx_reg   <= eidx_reg + 2'd1;
                        case (eidx_reg)
                            2'd0:    x_reg  <= e_val;
                            2'd1:    vx_reg <= e_val;
                            default: y_reg  <= e_val;
                        endcase
                    end
                    else if (!out_valid_reg || out_ready)
                    begin
                        vy_reg        <= e_val;
                        elapsed_reg   <= t_next;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            okes_pkg::S_SQY:
            begin
                sq_rem_reg <= mul_p;
            end
            okes_pkg::S_SQSUM:
            begin
                sq_rem_reg <= sq_rem_reg + mul_p;
                sq_res_reg <= '0;
                sq_bit_reg <= {2'b01, {(okes_pkg::SQ_W-2){1'b0}}};
                sq_cnt_reg <= '0;
            end
            okes_pkg::S_SQRT:
            begin
                sq_rem_reg <= sq_rem_new;
                sq_res_reg <= sq_res_new;
                sq_bit_reg <= sq_bit_reg >> 2;
                sq_cnt_reg <= sq_cnt_reg + 5'd1;
            end
            okes_pkg::S_CUBE_B:
            begin
                rr_hi_reg <= mul_p[2*DW-1:DW];
            end
            okes_pkg::S_CUBE_C:
            begin
                den_reg <= okes_pkg::DEN_W'(mul_p);
            end
            okes_pkg::S_CUBE_D:
            begin
                den_reg    <= den_reg + (okes_pkg::DEN_W'(mul_p) << DW);
                dv_dsh_reg <= okes_pkg::DSH_W'(den_reg + (okes_pkg::DEN_W'(mul_p) << DW))
                              << (DW - 1);
                dv_rem_reg <= okes_pkg::NUM_W'(okes_pkg::mag32(x_reg)) << (3 * FB);
                dv_cnt_reg <= 5'd31;
                dv_q_reg   <= '0;
            end
            okes_pkg::S_DIV:
            begin
                if (dv_done)
                begin
                    dv_dsh_reg <= okes_pkg::DSH_W'(den_reg) << (DW - 1);
                    dv_rem_reg <= okes_pkg::NUM_W'(okes_pkg::mag32(y_reg)) << (3 * FB);
                    dv_cnt_reg <= 5'd31;
                    dv_q_reg   <= '0;
                end
                else
                begin
                    dv_dsh_reg <= dv_dsh_reg >> 1;
                    dv_rem_reg <= dv_rem_new;
                    dv_cnt_reg <= dv_cnt_reg - 5'd1;
                    dv_q_reg   <= dv_q_new;
                end
            end
            okes_pkg::S_EMUL:
            begin
                if (ephase_reg && eidx_reg == 2'd3 && (!out_valid_reg || out_ready))
                begin
                    out_item_reg.new_x       <= x_reg;
                    out_item_reg.new_vx      <= vx_reg;
                    out_item_reg.new_y       <= y_reg;
                    out_item_reg.new_vy      <= e_val;
                    out_item_reg.step_time   <= elapsed_reg;
                    out_item_reg.zero_radius <= zr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    // A step request at or past the end time leaves the block idle.
    a_late_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_item.command == okes_pkg::CMD_STEP && step_late
        |=> state_reg == okes_pkg::S_IDLE)
        else $error("late step request started a computation");

    // A load request clears the elapsed time.
    a_load_clears_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_item.command == okes_pkg::CMD_LOAD |=> elapsed_reg == '0)
        else $error("load request did not clear elapsed time");

    // A new result is only published when the output register is free.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("pending result overwritten");

    // A division never runs for a zero radius.
    a_zero_radius_skip: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == okes_pkg::S_DIV |-> !zr_reg)
        else $error("division ran with zero radius");
`endif

endmodule

// File: rtl/kepler_orbit_euler_step.sv
`timescale 1ns / 1ps

// Explicit Euler two-body orbit stepper in signed Q16.16. A load request sets
// x, vx, y, vy and clears elapsed time without a result; a step request made
// while elapsed time is below end_time returns the new state, the time at the
// start of the step and a zero-radius flag, then advances time by step_size.
// A step runs a bit-serial 32-iteration square root, two 32-iteration
// restoring divisions and nine passes through the one shared 32 x 32
// multiplier; a saturating quotient ends its division early and a zero
// radius skips the cube and the divisions. Requests are refused while a step
// is in progress. The user must write configuration through cfg_we, cfg_index
// and cfg_wdata only while the block is idle; the block does not enforce it.
module kepler_orbit_euler_step (
    input  logic                         clk,
    input  logic                         rst_n,
    okes_in_if.sink                      in_ch,
    okes_out_if.source                   out_ch,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [okes_pkg::TIME_W-1:0]  cfg_wdata
);

    okes_pkg::cfg_t      cfg_reg;
    okes_pkg::in_item_t  in_item;
    okes_pkg::out_item_t out_item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size <= okes_pkg::STEP_SIZE_RST;
            cfg_reg.end_time  <= okes_pkg::END_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                okes_pkg::REG_STEP_SIZE: cfg_reg.step_size <= cfg_wdata;
                okes_pkg::REG_END_TIME:  cfg_reg.end_time  <= cfg_wdata;
                default:                 cfg_reg.end_time  <= cfg_reg.end_time;
            endcase
        end
    end

    assign in_item.command = in_ch.command;
    assign in_item.load_x  = in_ch.load_x;
    assign in_item.load_vx = in_ch.load_vx;
    assign in_item.load_y  = in_ch.load_y;
    assign in_item.load_vy = in_ch.load_vy;

    okes_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_item   (in_item),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_item)
    );

    assign out_ch.new_x       = out_item.new_x;
    assign out_ch.new_vx      = out_item.new_vx;
    assign out_ch.new_y       = out_item.new_y;
    assign out_ch.new_vy      = out_item.new_vy;
    assign out_ch.step_time   = out_item.step_time;
    assign out_ch.zero_radius = out_item.zero_radius;

endmodule

// File: bench/okes_tb_if.sv
`timescale 1ns / 1ps

// Write port of the configuration registers, driven by the bench and watched by the checker.
interface okes_cfg_if;
    logic                        we;
    logic                        index;
    logic [okes_pkg::TIME_W-1:0] wdata;
endinterface

// File: bench/okes_checker.sv
`timescale 1ns / 1ps

module okes_checker (
    input  logic        clk,
    input  logic        rst_n,
    okes_in_if          in_ch,
    okes_out_if         out_ch,
    okes_cfg_if         cfg,
    output int          errors,
    output int          pending
);

    logic [okes_pkg::TIME_W-1:0]        dt_reg;
    logic [okes_pkg::TIME_W-1:0]        end_reg;
    logic signed [okes_pkg::DATA_W-1:0] px, vx, py, vy;
    logic [okes_pkg::TIME_W-1:0]        clock_now;
    okes_pkg::out_item_t                orbit_q[$];

    assign pending = orbit_q.size();

    function automatic logic signed [okes_pkg::DATA_W-1:0] clamp32(
        input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return okes_pkg::S32_MAX;
        if (v < -128'sd2147483648)
            return okes_pkg::S32_MIN;
        return v[okes_pkg::DATA_W-1:0];
    endfunction

    // Integer square root of a 64-bit value by bisection on the result.
    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = 0;
        hi = 64'h1_0000_0000;
        while (hi - lo > 1)
        begin
            mid = (lo + hi) >> 1;
            if ({64'd0, mid} * {64'd0, mid} <= {64'd0, v})
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // Pull toward the origin along one axis: -c * 2^(3F) / r^3, quotient capped at 2^31.
    function automatic logic signed [okes_pkg::DATA_W-1:0] pull(
        input logic signed [okes_pkg::DATA_W-1:0] c,
        input logic [63:0] r);
        logic [255:0] num;
        logic [255:0] den;
        logic [255:0] quo;
        logic signed [127:0] sq;
        if (c == 0)
            return '0;
        num = 256'(c < 0 ? -128'(c) : 128'(c)) << (3 * okes_pkg::FRAC_BITS);
        den = 256'(r) * 256'(r) * 256'(r);
        quo = num / den;
        if (quo > 256'h8000_0000)
            quo = 256'h8000_0000;
        sq = 128'(quo);
        return c > 0 ? clamp32(-sq) : clamp32(sq);
    endfunction

    // One Euler update: base + floor(dt * rate / 2^F), saturated.
    function automatic logic signed [okes_pkg::DATA_W-1:0] advance(
        input logic signed [okes_pkg::DATA_W-1:0] base,
        input logic signed [okes_pkg::DATA_W-1:0] rate,
        input logic [okes_pkg::TIME_W-1:0] dt);
        logic signed [127:0] p;
        p = 128'(rate) * $signed({97'd0, dt});
        return clamp32(128'(base) + (p >>> okes_pkg::FRAC_BITS));
    endfunction

    // Track configuration writes, requests and results.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg    <= okes_pkg::STEP_SIZE_RST;
            end_reg   <= okes_pkg::END_TIME_RST;
            px        <= '0;
            vx        <= '0;
            py        <= '0;
            vy        <= '0;
            clock_now <= '0;
            errors    <= 0;
            orbit_q.delete();
        end
        else
        begin
            if (cfg.we)
            begin
                if (cfg.index == okes_pkg::REG_STEP_SIZE)
                    dt_reg <= cfg.wdata;
                else
                    end_reg <= cfg.wdata;
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.command == okes_pkg::CMD_LOAD)
                begin
                    px        <= in_ch.load_x;
                    vx        <= in_ch.load_vx;
                    py        <= in_ch.load_y;
                    vy        <= in_ch.load_vy;
                    clock_now <= '0;
                end
                else if (clock_now < end_reg)
                begin
                    okes_pkg::out_item_t e;
                    logic [63:0] r;
                    logic signed [okes_pkg::DATA_W-1:0] ax, ay;
                    logic [31:0] t;
                    r = root64(64'(128'(px) * 128'(px) + 128'(py) * 128'(py)));
                    if (r == 0)
                    begin
                        ax = okes_pkg::S32_MIN;
                        ay = okes_pkg::S32_MIN;
                    end
                    else
                    begin
                        ax = pull(px, r);
                        ay = pull(py, r);
                    end
                    e.new_x       = advance(px, vx, dt_reg);
                    e.new_vx      = advance(vx, ax, dt_reg);
                    e.new_y       = advance(py, vy, dt_reg);
                    e.new_vy      = advance(vy, ay, dt_reg);
                    e.step_time   = clock_now;
                    e.zero_radius = (r == 0);
                    orbit_q.push_back(e);
                    px <= e.new_x;
                    vx <= e.new_vx;
                    py <= e.new_y;
                    vy <= e.new_vy;
                    t = 32'(clock_now) + 32'(dt_reg);
                    clock_now <= t > 32'(okes_pkg::TIME_MAX) ? okes_pkg::TIME_MAX
                                                              : t[okes_pkg::TIME_W-1:0];
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (orbit_q.size() == 0)
                begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected result x=%h vx=%h y=%h vy=%h t=%h z=%b",
                                 out_ch.new_x, out_ch.new_vx, out_ch.new_y,
                                 out_ch.new_vy, out_ch.step_time, out_ch.zero_radius);
                end
                else
                begin
                    okes_pkg::out_item_t e;
                    e = orbit_q.pop_front();
                    if (out_ch.new_x !== e.new_x || out_ch.new_vx !== e.new_vx ||
                        out_ch.new_y !== e.new_y || out_ch.new_vy !== e.new_vy ||
                        out_ch.step_time !== e.step_time ||
                        out_ch.zero_radius !== e.zero_radius)
                    begin
                        errors <= errors + 1;
                        if (errors < 10)
                        begin
                            $display("mismatch exp x=%h vx=%h y=%h vy=%h t=%h z=%b",
                                     e.new_x, e.new_vx, e.new_y, e.new_vy,
                                     e.step_time, e.zero_radius);
                            $display("         got x=%h vx=%h y=%h vy=%h t=%h z=%b",
                                     out_ch.new_x, out_ch.new_vx, out_ch.new_y,
                                     out_ch.new_vy, out_ch.step_time, out_ch.zero_radius);
                        end
                    end
                end
            end
        end
    end

endmodule

// File: bench/tb_kepler_orbit_euler_step.sv
`timescale 1ns / 1ps

module tb_kepler_orbit_euler_step;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   idle_cycles = 0;
    int   sent;
    int   stall_phase = 0;

    okes_in_if  in_ch();
    okes_out_if out_ch();
    okes_cfg_if cfg();

    kepler_orbit_euler_step u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg.we),
        .cfg_index (cfg.index),
        .cfg_wdata (cfg.wdata)
    );

    okes_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #4 clk = ~clk;
    end

    // Receiver stalls: alternating spans of always-ready and random back-pressure.
    always @(negedge clk)
    begin
        stall_phase <= (stall_phase + 1) % 600;
        if (stall_phase < 150)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic cmd, input logic [31:0] x, input logic [31:0] dx,
                                input logic [31:0] y, input logic [31:0] dy);
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.load_x  <= x;
        in_ch.load_vx <= dx;
        in_ch.load_y  <= y;
        in_ch.load_vy <= dy;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        sent++;
        // Burst/gap pacing of the sender.
        if (sent % $urandom_range(3, 12) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(negedge clk);
        end
    endtask

    task automatic step_request();
        send_request(okes_pkg::CMD_STEP, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Hold off until all results are back and the block has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [okes_pkg::TIME_W-1:0] val);
        cfg.we    <= 1'b1;
        cfg.index <= idx;
        cfg.wdata <= val;
        @(negedge clk);
        cfg.we    <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [31:0] orbit_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return 32'($signed($urandom_range(0, 1 << 19)) + (1 << 16));
        endcase
    endfunction

    initial
    begin
        int lap;
        int n;
        in_ch.valid   = 1'b0;
        in_ch.command = okes_pkg::CMD_LOAD;
        in_ch.load_x  = '0;
        in_ch.load_vx = '0;
        in_ch.load_y  = '0;
        in_ch.load_vy = '0;
        cfg.we        = 1'b0;
        cfg.index     = okes_pkg::REG_STEP_SIZE;
        cfg.wdata     = '0;
        sent          = 0;
        rst_n         = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: step from the reset state (zero radius), extremes, unit circle.
        step_request();
        send_request(okes_pkg::CMD_LOAD, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                     32'h80000000);
        step_request();
        step_request();
        send_request(okes_pkg::CMD_LOAD, 32'h80000000, 32'h80000000, 32'h7fffffff,
                     32'h7fffffff);
        step_request();
        send_request(okes_pkg::CMD_LOAD, 32'h00000001, 0, 32'hffffffff, 0);
        step_request();
        send_request(okes_pkg::CMD_LOAD, 0, 0, 0, 32'hffffffff);
        step_request();
        send_request(okes_pkg::CMD_LOAD, 32'h00010000, 0, 0, 32'h00010000);
        repeat (5) step_request();
        drain();
        // Largest step: time saturates and stepping ends after one result.
        write_reg(okes_pkg::REG_STEP_SIZE, okes_pkg::TIME_MAX);
        write_reg(okes_pkg::REG_END_TIME, okes_pkg::TIME_MAX);
        send_request(okes_pkg::CMD_LOAD, 32'h00010000, 32'hffff0000, 32'h00020000,
                     32'h00000100);
        repeat (3) step_request();
        drain();
        // Zero end time: no step ever produces a result.
        write_reg(okes_pkg::REG_END_TIME, '0);
        write_reg(okes_pkg::REG_STEP_SIZE, 1);
        send_request(okes_pkg::CMD_LOAD, 32'h00010000, 0, 0, 32'h00010000);
        repeat (3) step_request();
        drain();

        // Random phases, each with its own step size and end time.
        for (lap = 0; lap < 6; lap++)
        begin
            write_reg(okes_pkg::REG_STEP_SIZE, lap == 5 ? okes_pkg::TIME_W'(0) :
                      okes_pkg::TIME_W'($urandom_range(1, lap == 4 ? 32'h7fffffff : 8000)));
            write_reg(okes_pkg::REG_END_TIME, lap == 3 ? okes_pkg::TIME_MAX :
                      okes_pkg::TIME_W'($urandom_range(0, 600000)));
            for (n = 0; n < 105; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(okes_pkg::CMD_LOAD, orbit_coord(), orbit_coord(),
                                 orbit_coord(), orbit_coord());
                else if ($urandom_range(0, 30) == 0)
                    send_request(okes_pkg::CMD_LOAD, $urandom, $urandom, $urandom, $urandom);
                else
                    step_request();
            end
            drain();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/okes_pkg.sv
rtl/okes_if.sv
rtl/okes_mul.sv
rtl/okes_core.sv
rtl/kepler_orbit_euler_step.sv
bench/okes_tb_if.sv
bench/okes_checker.sv
bench/tb_kepler_orbit_euler_step.sv
